FILE: design/gbsa_pkg.sv
// Package for the glyph blit saturating-add unit: mode and register codes,
// canvas store sizing and the store index helper. No dependencies.
`default_nettype none

package gbsa_pkg;

  localparam int unsigned CANVAS_PIXELS = 65536;
  localparam int unsigned STORE_AW      = $clog2(CANVAS_PIXELS);
  localparam logic [7:0]  SAT_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_BLEND = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_GLYPH_WIDTH   = 3'd2,
    REG_GLYPH_ROWS    = 3'd3,
    REG_X_OFFSET      = 3'd4,
    REG_Y_OFFSET      = 3'd5
  } reg_index_t;

  typedef logic [STORE_AW-1:0] store_addr_t;

  // Canvas index reduced to a store address (the store depth is a power of two).
  function automatic store_addr_t store_index(input logic [15:0] idx);
    logic [STORE_AW+15:0] wide;
    wide = {{STORE_AW{1'b0}}, idx};
    return wide[STORE_AW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/gbsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module gbsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/glyph_blit_saturating_add_unit.sv
// Top level of the glyph blit saturating-add unit: glyph counters, clipping,
// canvas address, read-modify-write pipeline. Depends on gbsa_pkg and gbsa_ram.
//
//   Channel  Direction  Signals
//   in       sink       in_valid/in_ready, in_mode, in_pixel_address, in_pixel_value
//   out      source     out_valid/out_ready, out_result_value, out_result_address,
//                       out_landed, out_glyph_last
//   cfg      sink       cfg_valid/cfg_ready, cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; a transaction passes through
// stage A, stage B and the output register before out_valid rises.
// The canvas memory is read one stage ahead of the write-back, and a write to
// the same entry in the same cycle is forwarded to the following transaction.
// A stalled output freezes the whole pipeline; cfg is always ready.
// Reset clears the counters and the pipeline valids and returns the registers to their defaults, not the canvas.
`default_nettype none

module glyph_blit_saturating_add_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_pixel_address,
  input  wire logic [7:0]  in_pixel_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result_value,
  output logic [15:0]      out_result_address,
  output logic             out_landed,
  output logic             out_glyph_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  logic [8:0] canvas_width_r;
  logic [8:0] canvas_height_r;
  logic [7:0] glyph_width_r;
  logic [7:0] glyph_rows_r;
  logic [8:0] x_offset_r;
  logic [8:0] y_offset_r;
  logic [7:0] glyph_col_r;
  logic [7:0] glyph_row_r;

  logic              en;
  logic              in_acc;
  logic              cfg_acc;
  gbsa_pkg::mode_t   in_mode_e;
  logic [9:0]        cx;
  logic [9:0]        cy;
  logic              on_canvas;
  logic [7:0]        col_end;
  logic [7:0]        row_end;
  logic              is_last;
  logic [7:0]        glyph_col_nxt;
  logic [7:0]        glyph_row_nxt;

  logic              a_valid_r;
  gbsa_pkg::mode_t   a_mode_r;
  logic [15:0]       a_addr_r;
  logic [7:0]        a_val_r;
  logic              a_hit_r;
  logic              a_last_r;
  logic [8:0]        a_cx_r;
  logic [8:0]        a_cy_r;
  logic [16:0]       a_idx;
  logic [15:0]       a_addr_eff;

  logic              b_valid_r;
  gbsa_pkg::mode_t   b_mode_r;
  logic [15:0]       b_addr_r;
  logic [7:0]        b_val_r;
  logic              b_hit_r;
  logic              b_last_r;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;
  logic [7:0]        ram_q;
  logic [7:0]        old_val;
  logic [8:0]        sum9;
  logic [7:0]        sat_val;
  logic              b_land;
  logic              b_wr;
  logic [7:0]        b_wdata;
  logic              fwd_hit_nxt;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_mode_e = gbsa_pkg::mode_t'(in_mode);

  // Clipping and counter advance for the incoming glyph pixel.
  always_comb begin
    cx        = {x_offset_r[8], x_offset_r} + {2'b00, glyph_col_r};
    cy        = {y_offset_r[8], y_offset_r} + {2'b00, glyph_row_r};
    on_canvas = !cx[9] && !cy[9] && (cx[8:0] < canvas_width_r) &&
                (cy[8:0] < canvas_height_r);
    col_end   = glyph_width_r - 8'd1;
    row_end   = glyph_rows_r - 8'd1;
    is_last   = 1'b0;
    if (glyph_col_r == col_end) begin
      glyph_col_nxt = 8'd0;
      if (glyph_row_r == row_end) begin
        glyph_row_nxt = 8'd0;
        is_last       = 1'b1;
      end else begin
        glyph_row_nxt = glyph_row_r + 8'd1;
      end
    end else begin
      glyph_col_nxt = glyph_col_r + 8'd1;
      glyph_row_nxt = glyph_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= 9'd256;
      canvas_height_r <= 9'd256;
      glyph_width_r   <= 8'd1;
      glyph_rows_r    <= 8'd1;
      x_offset_r      <= 9'd0;
      y_offset_r      <= 9'd0;
      glyph_col_r     <= 8'd0;
      glyph_row_r     <= 8'd0;
    end else if (cfg_acc) begin
      glyph_col_r <= 8'd0;
      glyph_row_r <= 8'd0;
      case (gbsa_pkg::reg_index_t'(cfg_index))
        gbsa_pkg::REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data;
        gbsa_pkg::REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data;
        gbsa_pkg::REG_GLYPH_WIDTH:   glyph_width_r   <= cfg_data[7:0];
        gbsa_pkg::REG_GLYPH_ROWS:    glyph_rows_r    <= cfg_data[7:0];
        gbsa_pkg::REG_X_OFFSET:      x_offset_r      <= cfg_data;
        gbsa_pkg::REG_Y_OFFSET:      y_offset_r      <= cfg_data;
        default: begin
        end
      endcase
    end else if (in_acc && in_mode_e == gbsa_pkg::MODE_BLEND) begin
      glyph_col_r <= glyph_col_nxt;
      glyph_row_r <= glyph_row_nxt;
    end
  end

  // Stage A: captured transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r <= in_mode_e;
      a_addr_r <= in_pixel_address;
      a_val_r  <= in_pixel_value;
      a_hit_r  <= on_canvas;
      a_last_r <= (in_mode_e == gbsa_pkg::MODE_BLEND) && is_last;
      a_cx_r   <= cx[8:0];
      a_cy_r   <= cy[8:0];
    end
  end

  // Canvas index and memory read address.
  always_comb begin
    a_idx = 17'(a_cy_r) * 17'(canvas_width_r) + 17'(a_cx_r);
    case (a_mode_r)
      gbsa_pkg::MODE_LOAD, gbsa_pkg::MODE_READ: a_addr_eff = a_addr_r;
      gbsa_pkg::MODE_BLEND: a_addr_eff = a_hit_r ? a_idx[15:0] : 16'd0;
      default: a_addr_eff = 16'd0;
    endcase
  end

  gbsa_ram #(
    .WIDTH (8),
    .DEPTH (gbsa_pkg::CANVAS_PIXELS)
  ) u_canvas (
    .clk   (clk),
    .we    (en && b_wr),
    .waddr (gbsa_pkg::store_index(b_addr_r)),
    .wdata (b_wdata),
    .re    (en),
    .raddr (gbsa_pkg::store_index(a_addr_eff)),
    .rdata (ram_q)
  );

  // Stage B: read data arrives, saturating add, write-back at the next advance.
  always_comb begin
    old_val = fwd_hit_r ? fwd_data_r : ram_q;
    sum9    = {1'b0, old_val} + {1'b0, b_val_r};
    sat_val = sum9[8] ? gbsa_pkg::SAT_MAX : sum9[7:0];
    b_land  = 1'b0;
    b_wr    = 1'b0;
    b_wdata = b_val_r;
    case (b_mode_r)
      gbsa_pkg::MODE_LOAD: begin
        b_land = 1'b1;
        b_wr   = b_valid_r;
      end
      gbsa_pkg::MODE_READ: begin
        b_land = 1'b1;
      end
      gbsa_pkg::MODE_BLEND: begin
        b_land  = b_hit_r;
        b_wr    = b_valid_r && b_hit_r;
        b_wdata = sat_val;
      end
      default: begin
      end
    endcase
    fwd_hit_nxt = a_valid_r && b_wr &&
                  (gbsa_pkg::store_index(b_addr_r) == gbsa_pkg::store_index(a_addr_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode_r   <= a_mode_r;
      b_addr_r   <= a_addr_eff;
      b_val_r    <= a_val_r;
      b_hit_r    <= a_hit_r;
      b_last_r   <= a_last_r;
      fwd_data_r <= b_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_address <= b_addr_r;
      out_landed         <= b_land;
      out_glyph_last     <= b_last_r;
      case (b_mode_r)
        gbsa_pkg::MODE_LOAD:  out_result_value <= b_val_r;
        gbsa_pkg::MODE_READ:  out_result_value <= old_val;
        gbsa_pkg::MODE_BLEND: out_result_value <= b_hit_r ? sat_val : 8'd0;
        default:              out_result_value <= 8'd0;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fwd_needs_reader : assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> b_valid_r)
    else $error("forwarded data held without a transaction in stage B");

  a_cfg_clears_counters : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> glyph_col_r == 8'd0 && glyph_row_r == 8'd0)
    else $error("glyph counters not cleared by a configuration write");

  a_counters_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    glyph_col_r <= col_end && glyph_row_r <= row_end)
    else $error("glyph counter beyond the glyph size");

  a_last_only_blend : assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_last_r |-> b_mode_r == gbsa_pkg::MODE_BLEND)
    else $error("glyph_last flagged on a non-blend transaction");
`endif

endmodule

`default_nettype wire
